FILE: sv/cdw_pkg.sv
// ----------------------------------------------------------------------------
// cdw_pkg: codepoint display width shared types and range tables
// Width codes, the result record and the three class tests over codepoints.
// ----------------------------------------------------------------------------
package cdw_pkg;

	localparam int CP_W = 21;
	localparam int COL_W = 2;

	localparam logic [COL_W-1:0] COL_ZERO   = 2'd0;
	localparam logic [COL_W-1:0] COL_NARROW = 2'd1;
	localparam logic [COL_W-1:0] COL_WIDE   = 2'd2;

	typedef logic [CP_W-1:0] cp_t;

	typedef struct packed {
		logic [COL_W-1:0] column_width;
		logic             wide_flag;
		logic             ambiguous_flag;
	} cdw_result_t;

	function automatic logic is_zero_width(cp_t cp);
		logic hit;
		case (cp) inside
			[21'h0000:21'h001F], [21'h007F:21'h009F], [21'h0300:21'h036F],
			[21'h1AB0:21'h1AFF], [21'h1DC0:21'h1DFF], [21'h20D0:21'h20FF],
			[21'hFE20:21'hFE2F], [21'h200B:21'h200F], 21'hFEFF,
			[21'hFE00:21'hFE0F], [21'h1160:21'h11FF]: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic is_wide(cp_t cp);
		logic hit;
		case (cp) inside
			[21'h1100:21'h115F], [21'h3000:21'h303E], [21'h4E00:21'h9FFF],
			[21'h3400:21'h4DBF], [21'h20000:21'h2A6DF], [21'h2A700:21'h2EBEF],
			[21'h30000:21'h3134F], [21'hF900:21'hFAFF], [21'hAC00:21'hD7A3],
			[21'h3131:21'h318E], [21'h3041:21'h3096], [21'h3099:21'h30FF],
			[21'h31F0:21'h31FF], [21'h3105:21'h312F], [21'h2E80:21'h2E99],
			[21'h2E9B:21'h2EF3], [21'h2F00:21'h2FD5], [21'h2FF0:21'h2FFB],
			[21'h3190:21'h31E3], [21'h3220:21'h3247], [21'hFE10:21'hFE19],
			[21'hFE30:21'hFE6F], [21'h2329:21'h232A], [21'hFF01:21'hFF60],
			[21'hFFE0:21'hFFE6], [21'hA000:21'hA4CF], [21'h2B50:21'h2B55],
			[21'h1F300:21'h1F64F], [21'h1F680:21'h1F6FF],
			[21'h1F900:21'h1FAFF], [21'h1F1E6:21'h1F1FF]: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic is_ambiguous(cp_t cp);
		logic hit;
		case (cp) inside
			21'h00A1, 21'h00A4, [21'h00A7:21'h00A8], 21'h00AA,
			[21'h00AD:21'h00AE], [21'h00B0:21'h00B4], [21'h00B6:21'h00BA],
			[21'h00BC:21'h00BF], 21'h00C6, 21'h00D0, [21'h00D7:21'h00D8],
			[21'h00DE:21'h00E1], 21'h00E6, [21'h00E8:21'h00EA],
			[21'h00EC:21'h00ED], 21'h00F0, [21'h00F2:21'h00F3],
			[21'h00F7:21'h00FA], 21'h00FC, 21'h00FE,
			[21'h0391:21'h03A1], [21'h03A3:21'h03A9], [21'h03B1:21'h03C1],
			[21'h03C3:21'h03C9], 21'h0401, [21'h0410:21'h044F], 21'h0451,
			21'h2010, [21'h2013:21'h2016], [21'h2018:21'h2019],
			[21'h201C:21'h201D], [21'h2020:21'h2022], [21'h2024:21'h2027],
			21'h2030, [21'h2032:21'h2033], 21'h2035, 21'h203B, 21'h203E,
			21'h20AC, 21'h2103, 21'h2105, 21'h2109, 21'h2113, 21'h2116,
			[21'h2121:21'h2122], 21'h2126, 21'h212B, [21'h2153:21'h2154],
			[21'h215B:21'h215E], [21'h2160:21'h216B], [21'h2170:21'h2179],
			21'h2189, [21'h2190:21'h2199], [21'h21B8:21'h21B9], 21'h21D2,
			21'h21D4, 21'h21E7,
			21'h2200, [21'h2202:21'h2203], [21'h2207:21'h2208], 21'h220B,
			21'h220F, 21'h2211, 21'h2215, 21'h221A, [21'h221D:21'h2220],
			21'h2223, 21'h2225, [21'h2227:21'h222C], 21'h222E,
			[21'h2234:21'h2237], [21'h223C:21'h223D], 21'h2248, 21'h224C,
			21'h2252, [21'h2260:21'h2261], [21'h2264:21'h2267],
			[21'h226A:21'h226B], [21'h226E:21'h226F], [21'h2282:21'h2283],
			[21'h2286:21'h2287], 21'h2295, 21'h2299, 21'h22A5, 21'h22BF,
			[21'h2300:21'h23FF], [21'h2460:21'h24E9], [21'h24EB:21'h254B],
			[21'h2550:21'h2573], [21'h2580:21'h258F], [21'h2592:21'h2595],
			[21'h25A0:21'h25A1], [21'h25A3:21'h25A9], [21'h25B2:21'h25B3],
			[21'h25B6:21'h25B7], [21'h25BC:21'h25BD], [21'h25C0:21'h25C1],
			[21'h25C6:21'h25C8], 21'h25CB, [21'h25CE:21'h25D1],
			[21'h25E2:21'h25E5], 21'h25EF,
			[21'h2600:21'h27BF], [21'hE000:21'hF8FF], 21'hFFFD,
			[21'hF0000:21'hFFFFD], [21'h100000:21'h10FFFD]: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

FILE: sv/cdw_classify.sv
// ----------------------------------------------------------------------------
// cdw_classify: codepoint class decode
// Range tests in priority order: zero width, wide, ambiguous, narrow.
// ----------------------------------------------------------------------------
module cdw_classify (
	input  cdw_pkg::cp_t        cp,
	input  logic                amb_wide,
	output cdw_pkg::cdw_result_t result
);
	import cdw_pkg::*;

	logic             zero_hit;
	logic             wide_hit;
	logic             amb_hit;
	logic [COL_W-1:0] cols;

	always_comb begin
		zero_hit = is_zero_width(cp);
		wide_hit = is_wide(cp);
		amb_hit  = is_ambiguous(cp);
		if (zero_hit) begin
			cols = COL_ZERO;
		end else if (wide_hit) begin
			cols = COL_WIDE;
		end else if (amb_hit && amb_wide) begin
			cols = COL_WIDE;
		end else begin
			cols = COL_NARROW;
		end
		result.column_width   = cols;
		result.wide_flag      = (cols == COL_WIDE);
		result.ambiguous_flag = amb_hit;
	end

endmodule

FILE: sv/codepoint_display_width.sv
// ----------------------------------------------------------------------------
// codepoint_display_width: terminal column width of a Unicode codepoint
// Input register, range decode, result register; one request per cycle while out_ready does not stall the output.
// ----------------------------------------------------------------------------
// A codepoint is registered in cp_s1, then decoded and registered in res_s2 before its result is offered.
// Throughput: one codepoint per cycle while out_ready does not stall it, set by the two-stage register pipeline.
// Reset (arst_n low, asynchronous): pipeline emptied, ambiguous width set to 1.
module codepoint_display_width (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cdw_pkg::cp_t                 code_point,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cdw_pkg::COL_W-1:0]    column_width,
	output logic                         wide_flag,
	output logic                         ambiguous_flag
);
	import cdw_pkg::*;

	logic [1:0]  amb_width_q;
	logic        valid_s1;
	cp_t         cp_s1;
	logic        valid_s2;
	cdw_result_t res_s2;
	cdw_result_t res_c;
	logic        adv_s1;
	logic        adv_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_width_q <= 2'd1;
		end else if (cfg_valid) begin
			amb_width_q <= cfg_data;
		end
	end

	// advance each stage when the one after it has room
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			cp_s1 <= code_point;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	cdw_classify u_classify (
		.cp       (cp_s1),
		.amb_wide (amb_width_q == COL_WIDE),
		.result   (res_c)
	);

	assign out_valid      = valid_s2;
	assign column_width   = res_s2.column_width;
	assign wide_flag      = res_s2.wide_flag;
	assign ambiguous_flag = res_s2.ambiguous_flag;

endmodule
